// ===== rtl/core/ipv4hb_pkg.sv =====
// Shared types and constants for the IPv4 transmit header builder.
`default_nettype none

package ipv4hb_pkg;

    localparam int BUFFER_BYTES = 1500;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TTL_DEFAULT = 8'd64;

    localparam int IN_W      = 56;
    localparam int OUT_W     = 64;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_IP    = 2'd0,
        CFG_SUBNET_MASK = 2'd1,
        CFG_GATEWAY_IP  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        W_VER_LEN  = 3'd0,
        W_IDENT    = 3'd1,
        W_TTL_CSUM = 3'd2,
        W_SRC      = 3'd3,
        W_DST      = 3'd4
    } t_word;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [31:0] subnet_mask;
        logic [31:0] gateway_ip;
    } t_cfg;

    typedef struct packed {
        logic             err;
        logic [31:0]      next_hop;
        logic [15:0]      tot_len;
        logic [15:0]      ident;
        logic [7:0]       protocol;
        logic [SUM_W-1:0] sum;
        logic [31:0]      dst_ip;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== rtl/core/ipv4_tx_header_builder.sv =====
// Top level of the IPv4 transmit header builder: configuration registers and the two halves.
`default_nettype none

// Each accepted request comes out as five header words (version/length, identification,
// TTL/protocol/checksum, source, destination), each carrying the chosen next hop, the
// fifth marked with tlast; a request longer than the buffer comes out as a single word
// with tuser set, zero data and tlast. The word sequencer sets the output rate, while
// a four-entry queue lets the slave side keep taking requests meanwhile. A request taken
// into an empty block passes through the queue and the current-request register into
// the output register. Configuration
// writes must only be made while no request is in flight.
module ipv4_tx_header_builder
    import ipv4hb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [31:0] dst_ip, [39:32] protocol, [55:40] payload_len
    input  wire logic [IN_W-1:0]      i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [31:0] next_hop, [63:32] header_word
    output logic [OUT_W-1:0]          o_m_axis_tdata,
    // [0] status
    output logic                      o_m_axis_tuser,
    output logic                      o_m_axis_tlast,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg    r_cfg;
    t_req    push_req;
    t_req    pop_req;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOCAL_IP:    r_cfg.local_ip    <= i_cfg_wdata;
                CFG_SUBNET_MASK: r_cfg.subnet_mask <= i_cfg_wdata;
                CFG_GATEWAY_IP:  r_cfg.gateway_ip  <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    ipv4hb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_req           (push_req)
    );

    ipv4hb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_req),
        .i_pop       (pop),
        .o_pop_data  (pop_req),
        .o_stat      (q_stat)
    );

    ipv4hb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_local_ip      (r_cfg.local_ip),
        .i_q_stat        (q_stat),
        .i_q_data        (pop_req),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ipv4hb_front.sv =====
// Front end: takes requests, checks length, picks next hop, assigns identification.
`default_nettype none

module ipv4hb_front
    import ipv4hb_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [IN_W-1:0] i_s_axis_tdata,
    input  wire t_q_stat         i_q_stat,
    output logic                 o_push,
    output t_req                 o_req
);

    logic [15:0] r_packet_id;
    logic [15:0] n_packet_id;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] payload_len;
    logic [16:0] total_wide;
    logic        too_long;
    logic        on_link;
    logic        accept;

    assign dst_ip      = i_s_axis_tdata[31:0];
    assign protocol    = i_s_axis_tdata[39:32];
    assign payload_len = i_s_axis_tdata[55:40];

    assign o_s_axis_tready = !i_q_stat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = accept;

    assign total_wide = {1'b0, payload_len} + {1'b0, HDR_BYTES};
    assign too_long   = total_wide > 17'(BUFFER_BYTES);
    assign on_link    = (dst_ip & i_cfg.subnet_mask) == (i_cfg.local_ip & i_cfg.subnet_mask);

    always_comb begin
        o_req.err      = too_long;
        o_req.next_hop = on_link ? dst_ip : i_cfg.gateway_ip;
        o_req.tot_len  = total_wide[15:0];
        o_req.ident    = r_packet_id;
        o_req.protocol = protocol;
        o_req.dst_ip   = dst_ip;
        // raw sum of the ten 16-bit header words, checksum field zero
        o_req.sum = SUM_W'({VER_IHL, 8'h00}) + SUM_W'({TTL_DEFAULT, 8'h00})
                  + SUM_W'(total_wide[15:0]) + SUM_W'(r_packet_id)
                  + SUM_W'(protocol)
                  + SUM_W'(i_cfg.local_ip[31:16]) + SUM_W'(i_cfg.local_ip[15:0])
                  + SUM_W'(dst_ip[31:16]) + SUM_W'(dst_ip[15:0]);
    end

    always_comb begin
        n_packet_id = r_packet_id;
        if (accept && !too_long) begin
            n_packet_id = r_packet_id + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_id <= '0;
        end else begin
            r_packet_id <= n_packet_id;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv4hb_queue.sv =====
// Short request queue between front end and word sequencer.
`default_nettype none

module ipv4hb_queue
    import ipv4hb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_push_data,
    input  wire logic i_pop,
    output t_req      o_pop_data,
    output t_q_stat   o_stat
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;

    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipv4hb_back.sv =====
// Back end: steps through the header words of each request into the output register.
`default_nettype none

module ipv4hb_back
    import ipv4hb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_local_ip,
    input  wire t_q_stat     i_q_stat,
    input  wire t_req        i_q_data,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    t_req             r_cur;
    logic             r_cur_valid;
    t_word            r_word;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_user;
    logic             r_out_last;

    logic        load;
    logic        emit;
    logic        cur_last;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;
    logic [31:0] hdr_word;

    assign load     = !r_out_valid || i_m_axis_tready;
    assign emit     = load && r_cur_valid;
    assign cur_last = r_cur.err || (r_word == W_DST);
    assign o_pop    = !i_q_stat.empty && (!r_cur_valid || (emit && cur_last));

    assign fold1 = {1'b0, r_cur.sum[15:0]} + 17'(r_cur.sum[SUM_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);
    assign csum  = ~fold2;

    always_comb begin
        unique case (r_word)
            W_VER_LEN:  hdr_word = {VER_IHL, 8'h00, r_cur.tot_len};
            W_IDENT:    hdr_word = {r_cur.ident, 16'h0000};
            W_TTL_CSUM: hdr_word = {TTL_DEFAULT, r_cur.protocol, csum};
            W_SRC:      hdr_word = i_local_ip;
            W_DST:      hdr_word = r_cur.dst_ip;
            default:    hdr_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
        end
        if (emit) begin
            r_out_data <= r_cur.err ? '0 : {hdr_word, r_cur.next_hop};
            r_out_user <= r_cur.err;
            r_out_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_word      <= W_VER_LEN;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_word      <= W_VER_LEN;
            end else if (emit) begin
                r_cur_valid <= !cur_last;
                r_word      <= t_word'(r_word + 3'd1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/ipv4hb_checker.sv =====
// Port-level checks for the IPv4 transmit header builder, bound to the top level.
`default_nettype none

module ipv4hb_checker
    import ipv4hb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_m_axis_tvalid,
    input wire logic             i_m_axis_tready,
    input wire logic [OUT_W-1:0] o_m_axis_tdata,
    input wire logic             o_m_axis_tuser,
    input wire logic             o_m_axis_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled request changed");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("rejected request not a single zero word");

    a_hop_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast && !o_m_axis_tuser |=>
            !o_m_axis_tvalid
            || (!o_m_axis_tuser && (o_m_axis_tdata[31:0] == $past(o_m_axis_tdata[31:0]))))
        else $error("next hop changed within a header");

endmodule

bind ipv4_tx_header_builder ipv4hb_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== bench/ipv4_tx_header_builder_tb.sv =====
// Self-checking testbench for the IPv4 transmit header builder: predicted header words vs stream output.
`timescale 1ns / 1ps

module ipv4_tx_header_builder_tb;
    import ipv4hb_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int          MAX_GAP        = 13;
    localparam logic [15:0] MAX_PAYLOAD    = 16'(BUFFER_BYTES) - HDR_BYTES;

    typedef struct packed {
        logic        status;
        logic [31:0] next_hop;
        logic [31:0] word;
        logic        last;
    } hdr_result_t;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              req_tvalid = 1'b0;
    logic              req_tready;
    logic [IN_W-1:0]   req_tdata  = '0;
    logic              res_tvalid;
    logic              res_tready = 1'b0;
    logic [OUT_W-1:0]  res_tdata;
    logic              res_tuser;
    logic              res_tlast;
    logic              cfg_wr_en  = 1'b0;
    t_cfg_idx          cfg_index  = CFG_LOCAL_IP;
    logic [CFG_W-1:0]  cfg_wdata  = '0;

    // predictor copy of the registers and the identification counter
    logic [31:0]       own_ip     = '0;
    logic [31:0]       sub_mask   = '0;
    logic [31:0]       gw_ip      = '0;
    logic [15:0]       next_ident = '0;

    hdr_result_t       expected_words[$];
    int                mismatches   = 0;
    bit                idle_en      = 1'b0;
    int                sink_wait    = 0;
    int                quiet_cycles = 0;

    ipv4_tx_header_builder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (req_tvalid),
        .o_s_axis_tready (req_tready),
        .i_s_axis_tdata  (req_tdata),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tuser  (res_tuser),
        .o_m_axis_tlast  (res_tlast),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string field, input logic [31:0] expd,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %h got %h at %0t", field, expd, got, $time);
        mismatches++;
    endtask

    // expected header words for one request
    task automatic build_header(input logic [31:0] dst, input logic [7:0] proto,
                                input logic [15:0] plen);
        logic [16:0] total;
        logic [31:0] hop;
        logic [31:0] w[5];
        logic [19:0] sum;
        begin
            total = {1'b0, HDR_BYTES} + {1'b0, plen};
            if (total > BUFFER_BYTES) begin
                expected_words.push_back('{1'b1, 32'h0, 32'h0, 1'b1});
                return;
            end
            hop  = ((dst & sub_mask) == (own_ip & sub_mask)) ? dst : gw_ip;
            w[0] = {VER_IHL, 8'h00, total[15:0]};
            w[1] = {next_ident, 16'h0000};
            w[2] = {TTL_DEFAULT, proto, 16'h0000};
            w[3] = own_ip;
            w[4] = dst;
            sum  = '0;
            for (int i = 0; i < 5; i++)
                sum = sum + w[i][31:16] + w[i][15:0];
            while (sum > 20'h0FFFF)
                sum = sum[15:0] + sum[19:16];
            w[2][15:0] = ~sum[15:0];
            for (int i = 0; i < 5; i++)
                expected_words.push_back('{1'b0, hop, w[i], i == 4});
            next_ident = next_ident + 16'd1;
        end
    endtask

    // valid is left high after acceptance; the next request or the drain decides
    task automatic send_request(input logic [31:0] dst, input logic [7:0] proto,
                                input logic [15:0] plen);
        int gap;
        begin
            gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                req_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            req_tvalid <= 1'b1;
            req_tdata  <= {plen, proto, dst};
            @(posedge i_clk);
            while (!req_tready) @(posedge i_clk);
            build_header(dst, proto, plen);
        end
    endtask

    task automatic drain_results();
        req_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] own, input logic [31:0] mask,
                              input logic [31:0] gw);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOCAL_IP;
        cfg_wdata <= own;
        @(posedge i_clk);
        cfg_index <= CFG_SUBNET_MASK;
        cfg_wdata <= mask;
        @(posedge i_clk);
        cfg_index <= CFG_GATEWAY_IP;
        cfg_wdata <= gw;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        own_ip   = own;
        sub_mask = mask;
        gw_ip    = gw;
    endtask

    // registers still at reset: zero mask puts every destination on-link
    task automatic test_reset_state();
        idle_en = 1'b0;
        send_request(32'h0000_0000, 8'h00, 16'd0);
        send_request(32'hFFFF_FFFF, 8'hFF, MAX_PAYLOAD);
        send_request(32'hA5A5_5A5A, 8'h11, 16'h005A);
        drain_results();
    endtask

    task automatic test_length_limit();
        logic [15:0] lens[7] = '{MAX_PAYLOAD, MAX_PAYLOAD + 16'd1, 16'hFFFF, 16'hFFEC,
                                 16'hFFEB, 16'd0, MAX_PAYLOAD - 16'd1};
        begin
            idle_en = 1'b1;
            foreach (lens[i])
                send_request($urandom, 8'($urandom), lens[i]);
            drain_results();
        end
    endtask

    task automatic test_next_hop();
        idle_en = 1'b1;
        set_config(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
        send_request(32'hC0A8_0177, 8'h06, 16'd40);
        send_request(32'h0808_0808, 8'h11, 16'd8);
        send_request(32'hC0A8_01FF, 8'h01, 16'd64);
        send_request(32'h40A8_010A, 8'h06, 16'd100);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 8'hFF, 16'd0);
        send_request(32'hFFFF_FFFE, 8'h00, 16'd1);
        send_request(32'h0000_0000, 8'h80, MAX_PAYLOAD);
        set_config(32'h0A00_0001, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0A00_0001, 8'h06, 16'd20);
        send_request(32'h0A00_0002, 8'h06, 16'd20);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [31:0] own;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [31:0] dst;
        logic [15:0] plen;
        int          prefix;
        begin
            idle_en = 1'b1;
            for (int phase = 0; phase < 4; phase++) begin
                prefix = $urandom_range(1, 31);
                own    = (phase == 1) ? 32'hFFFF_FFFF : $urandom;
                gw     = (phase == 1) ? 32'h0000_0000 : $urandom;
                case (phase)
                    0:       mask = 32'h0000_0000;
                    1:       mask = 32'hFFFF_FFFF;
                    default: mask = 32'hFFFF_FFFF << (32 - prefix);
                endcase
                set_config(own, mask, gw);
                for (int n = 0; n < 21; n++) begin
                    dst = $urandom;
                    if ($urandom_range(0, 1))
                        dst = (own & mask) | (dst & ~mask);
                    case ($urandom_range(0, 9))
                        7:       plen = 16'($urandom_range(MAX_PAYLOAD - 10, MAX_PAYLOAD + 10));
                        8:       plen = 16'($urandom_range(MAX_PAYLOAD + 1, 16'hFFFF));
                        9:       plen = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                        default: plen = 16'($urandom_range(0, MAX_PAYLOAD));
                    endcase
                    // hold the sender off until the output side has caught up
                    if (n == 10)
                        drain_results();
                    send_request(dst, 8'($urandom), plen);
                end
            end
            drain_results();
        end
    endtask

    // rejected requests between accepted ones leave the identification alone
    task automatic test_ident_hold();
        idle_en = 1'b0;
        set_config(32'h0A01_0203, 32'hFFFF_0000, 32'h0A01_0001);
        send_request(32'h0A01_0909, 8'h06, 16'd10);
        send_request(32'h0A01_0909, 8'h06, 16'hFFFF);
        send_request(32'h0A01_0909, 8'h06, MAX_PAYLOAD + 16'd1);
        send_request(32'hC000_0001, 8'h11, 16'd10);
        send_request(32'hC000_0001, 8'h11, 16'hFFEC);
        send_request(32'hC000_0001, 8'h11, 16'd0);
        drain_results();
    endtask

    always @(posedge i_clk) begin : result_check
        hdr_result_t exp_word;
        if (i_rst_n && res_tvalid && res_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 32'h0, res_tdata[63:32]);
            end else begin
                exp_word = expected_words.pop_front();
                if (res_tuser !== exp_word.status)
                    report_mismatch("status", exp_word.status, res_tuser);
                if (res_tdata[31:0] !== exp_word.next_hop)
                    report_mismatch("next_hop", exp_word.next_hop, res_tdata[31:0]);
                if (res_tdata[63:32] !== exp_word.word)
                    report_mismatch("header_word", exp_word.word, res_tdata[63:32]);
                if (res_tlast !== exp_word.last)
                    report_mismatch("last_word", exp_word.last, res_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_tready <= 1'b0;
        end else if (res_tvalid && res_tready) begin
            sink_wait = idle_en ? $urandom_range(0, MAX_GAP) : 0;
            res_tready <= (sink_wait == 0);
        end else if (!res_tready) begin
            if (sink_wait > 0)
                sink_wait = sink_wait - 1;
            else
                res_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_tvalid && req_tready) || (res_tvalid && res_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ipv4_tx_header_builder test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_length_limit();
        test_next_hop();
        test_random_traffic();
        test_ident_hold();
        drain_results();
        if (mismatches == 0)
            $display("ipv4_tx_header_builder test passed");
        else
            $display("ipv4_tx_header_builder test failed");
        $finish;
    end

endmodule
